// ----- rtl/fat12_cluster_chain_seek_macros.svh -----
// Assertion macros for the cluster chain seek block.
// Taken in by the top level with `include; depends on nothing else.
`ifndef FAT12_CLUSTER_CHAIN_SEEK_MACROS_SVH
`define FAT12_CLUSTER_CHAIN_SEEK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FAT12CCS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FAT12CCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/fat12ccs_pkg.sv -----
// Shared types and constants of the cluster chain seek block.
// Used by fat12ccs_table and fat12_cluster_chain_seek; depends on nothing.
`timescale 1ns / 1ps

package fat12ccs_pkg;

  localparam int ADDR_W = 13;          // table byte address width
  localparam int ADDR_SPAN = 2 ** ADDR_W;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_OPEN = 2'd1,
    KIND_SEEK = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_EOC = 2'd1,
    STAT_EIO = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_READ,
    SEQ_EVAL
  } seq_state_e;

  localparam logic [11:0] LINK_END      = 12'hFF8;
  localparam logic [11:0] LINK_RESERVED = 12'hFF0;
  localparam logic [11:0] LINK_MASK     = 12'hFFF;
  localparam logic [3:0]  NIBBLE        = 4'hF;
  localparam logic [15:0] SECTOR_SAT    = 16'hFFFF;
  localparam logic [15:0] TOTAL_RESET   = 16'd2880;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } tbl_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] idx;   // byte index 3c/2 of the entry
    logic              odd;   // cluster number is odd
  } tbl_rd_t;

endpackage

// ----- rtl/fat12_cluster_chain_seek.sv -----
// Top level of the FAT12 cluster chain seek block.
// Depends on fat12ccs_pkg, fat12ccs_table and fat12_cluster_chain_seek_macros.svh.
`timescale 1ns / 1ps

// The block keeps a packed 12-bit FAT in on-chip memory and walks a file's
// cluster chain for byte offset seeks. Every input word yields exactly one
// output word carrying status, current cluster and its data sector. A load
// word writes one table byte (addresses past the table are ignored), an open
// word selects a file by start cluster and rewinds, and a seek word turns the
// byte offset into a sector index and follows the chain one link per sector,
// from the remembered sector or from the start when the index goes back.
// Load, open and unknown words finish in the cycle in which they are
// accepted; their result word is valid from the next cycle. A seek walks
// one hop per sector: each hop is a synchronous read of the table banks in
// the read state followed by the evaluate state, which decodes and checks
// the entry; the walk stops early when a hop fails. One word is handled at
// a time; the finished result sits in an output register, and a new word
// is accepted no earlier than the cycle in which that result is taken. The
// table holds no reset value and needs no clearing pass; every entry read
// must have been loaded first. total_sectors resets to 2880 and may be
// rewritten only while the block is idle.
module fat12_cluster_chain_seek #(
  parameter int SECTOR_BYTES = 512,
  parameter int FAT_SECTORS  = 9,
  parameter int DATA_START   = 33
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input words.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [12:0] table_addr, [20:13] table_byte, [32:21] first_cluster,
  // [57:33] byte_offset, [63:58] zero
  input  logic [63:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser,
  // Result words.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [13:2] cluster, [29:14] sector, [31:30] zero
  output logic [31:0] m_axis_tdata,
  // Configuration: total_sectors.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int TableBytes = FAT_SECTORS * SECTOR_BYTES;
  localparam int MemBytes   = (TableBytes < fat12ccs_pkg::ADDR_SPAN) ?
                              TableBytes : fat12ccs_pkg::ADDR_SPAN;
  localparam int SectShift  = $clog2(SECTOR_BYTES);
  localparam logic [16:0] TableLim = 17'(TableBytes);
  localparam logic [16:0] DsecOff  = 17'(DATA_START - 2);

  // Input word fields.
  logic [1:0]  in_kind;
  logic [12:0] in_addr;
  logic [7:0]  in_byte;
  logic [11:0] in_first;
  logic [24:0] in_offs;

  assign in_kind  = s_axis_tuser;
  assign in_addr  = s_axis_tdata[12:0];
  assign in_byte  = s_axis_tdata[20:13];
  assign in_first = s_axis_tdata[32:21];
  assign in_offs  = s_axis_tdata[57:33];

  // Architectural state.
  logic [11:0] start_q, start_d;
  logic [11:0] cur_q, cur_d;
  logic [15:0] recent_q, recent_d;
  logic [15:0] total_q;

  // Walk state.
  fat12ccs_pkg::seq_state_e state_q, state_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] target_q, target_d;

  // Result register.
  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_status_q, out_status_d;
  logic [11:0] out_cluster_q;
  logic [15:0] out_sector_q;

  logic accept, out_free, done;
  fat12ccs_pkg::status_e done_status;

  // Seek entry values.
  logic [24:0] tgt_full;
  logic [15:0] tgt;
  logic        tgt_back;
  logic [15:0] pos_start;

  // Hop checks.
  logic [16:0] cur_dsec;
  logic [13:0] cur_x3;
  logic [12:0] cur_idx;
  logic        chk_fail;
  logic [15:0] pos_inc;
  logic [11:0] entry;
  logic        ent_eoc, ent_eio;

  fat12ccs_pkg::tbl_wr_t tbl_wr;
  fat12ccs_pkg::tbl_rd_t tbl_rd;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == fat12ccs_pkg::SEQ_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_sector_q, out_cluster_q, out_status_q};

  // The sector index saturates at 16 bits.
  assign tgt_full  = in_offs >> SectShift;
  assign tgt       = (|tgt_full[24:16]) ? fat12ccs_pkg::SECTOR_SAT : tgt_full[15:0];
  assign tgt_back  = tgt < recent_q;
  assign pos_start = tgt_back ? 16'd0 : recent_q;

  // A cluster is checked against the volume size and against the table end
  // before its entry is read.
  assign cur_dsec = {5'b0, cur_q} + DsecOff;
  assign cur_x3   = {1'b0, cur_q, 1'b0} + {2'b0, cur_q};
  assign cur_idx  = cur_x3[13:1];
  assign chk_fail = (cur_dsec > {1'b0, total_q}) ||
                    (({4'b0, cur_idx} + 17'd1) >= TableLim);
  assign pos_inc  = pos_q + 16'd1;

  assign ent_eoc = entry >= fat12ccs_pkg::LINK_END;
  assign ent_eio = (entry >= fat12ccs_pkg::LINK_RESERVED) || (entry == 12'd0);

  // Table writes happen only on accepted load words in the idle state and
  // reads only during a walk, so a read never meets a write to the same
  // entry and no forwarding is needed.
  assign tbl_wr.en   = accept && (in_kind == fat12ccs_pkg::KIND_LOAD) &&
                       ({4'b0, in_addr} < TableLim);
  assign tbl_wr.addr = in_addr;
  assign tbl_wr.data = in_byte;

  assign tbl_rd.en  = (state_q == fat12ccs_pkg::SEQ_READ) && out_free && !chk_fail;
  assign tbl_rd.idx = cur_idx;
  assign tbl_rd.odd = cur_q[0];

  fat12ccs_table #(
    .MemBytes(MemBytes)
  ) u_table (
    .clk_i  (clk_i),
    .wr_i   (tbl_wr),
    .rd_i   (tbl_rd),
    .entry_o(entry)
  );

  // Next state of the walk sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fat12ccs_pkg::SEQ_IDLE: begin
        if (accept && (in_kind == fat12ccs_pkg::KIND_SEEK) && (tgt != pos_start)) begin
          state_d = fat12ccs_pkg::SEQ_READ;
        end
      end
      fat12ccs_pkg::SEQ_READ: begin
        if (out_free) begin
          state_d = chk_fail ? fat12ccs_pkg::SEQ_IDLE : fat12ccs_pkg::SEQ_EVAL;
        end
      end
      fat12ccs_pkg::SEQ_EVAL: begin
        if (out_free) begin
          if (ent_eoc || ent_eio || (pos_inc == target_q)) begin
            state_d = fat12ccs_pkg::SEQ_IDLE;
          end else begin
            state_d = fat12ccs_pkg::SEQ_READ;
          end
        end
      end
      default: state_d = fat12ccs_pkg::SEQ_IDLE;
    endcase
  end

  // Datapath updates and completion of a word.
  always_comb begin
    start_d     = start_q;
    cur_d       = cur_q;
    recent_d    = recent_q;
    pos_d       = pos_q;
    target_d    = target_q;
    done        = 1'b0;
    done_status = fat12ccs_pkg::STAT_OK;
    unique case (state_q)
      fat12ccs_pkg::SEQ_IDLE: begin
        if (accept) begin
          done = 1'b1;
          case (in_kind)
            fat12ccs_pkg::KIND_OPEN: begin
              start_d  = in_first;
              cur_d    = in_first;
              recent_d = 16'd0;
            end
            fat12ccs_pkg::KIND_SEEK: begin
              if (tgt_back) begin
                cur_d = start_q;
              end
              pos_d    = pos_start;
              target_d = tgt;
              if (tgt == pos_start) begin
                recent_d = tgt;
              end else begin
                done = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      fat12ccs_pkg::SEQ_READ: begin
        if (out_free && chk_fail) begin
          done        = 1'b1;
          done_status = fat12ccs_pkg::STAT_EIO;
        end
      end
      fat12ccs_pkg::SEQ_EVAL: begin
        if (out_free) begin
          if (ent_eoc) begin
            done        = 1'b1;
            done_status = fat12ccs_pkg::STAT_EOC;
          end else if (ent_eio) begin
            done        = 1'b1;
            done_status = fat12ccs_pkg::STAT_EIO;
          end else begin
            cur_d = entry;
            pos_d = pos_inc;
            if (pos_inc == target_q) begin
              done     = 1'b1;
              recent_d = target_q;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d  = done ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  assign out_status_d = done_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fat12ccs_pkg::SEQ_IDLE;
      start_q     <= 12'd0;
      cur_q       <= 12'd0;
      recent_q    <= 16'd0;
      pos_q       <= 16'd0;
      target_q    <= 16'd0;
      total_q     <= fat12ccs_pkg::TOTAL_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      cur_q       <= cur_d;
      recent_q    <= recent_d;
      pos_q       <= pos_d;
      target_q    <= target_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        total_q <= cfg_data_i;
      end
    end
  end

  // The result payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (done) begin
      out_status_q  <= out_status_d;
      out_cluster_q <= cur_d;
      out_sector_q  <= 16'({5'b0, cur_d} + DsecOff);
    end
  end

`include "fat12_cluster_chain_seek_macros.svh"

  // A walk in progress has not yet reached its target sector.
  `FAT12CCS_ASSERT_SAME(walk_below_target, clk_i, rst_ni, state_q != fat12ccs_pkg::SEQ_IDLE, pos_q < target_q, "walk position reached or passed its target")
  // A table read is always followed by the cycle that decodes it.
  `FAT12CCS_ASSERT_NEXT(read_then_eval, clk_i, rst_ni, tbl_rd.en, state_q == fat12ccs_pkg::SEQ_EVAL, "table read not followed by entry decode")
  // A finished word never overwrites a result that is still waiting.
  `FAT12CCS_ASSERT_SAME(done_has_room, clk_i, rst_ni, done, out_free, "result register overwritten while full")

endmodule

// ----- rtl/fat12ccs_table.sv -----
// Packed FAT table held as an even and an odd byte bank, so that the two
// bytes of a 12-bit entry come out of one read. Depends on fat12ccs_pkg.
`timescale 1ns / 1ps

module fat12ccs_table #(
  parameter int MemBytes = 4608
) (
  input  logic                 clk_i,
  input  fat12ccs_pkg::tbl_wr_t wr_i,
  input  fat12ccs_pkg::tbl_rd_t rd_i,
  output logic [11:0]          entry_o
);

  localparam int Rows = (MemBytes + 1) / 2;
  localparam int RowW = $clog2(Rows);

  logic [7:0] even_mem [Rows];
  logic [7:0] odd_mem  [Rows];

  logic [fat12ccs_pkg::ADDR_W-1:0] idx_p1;
  logic [7:0] even_q, odd_q;
  logic       sel_q, codd_q;
  logic [7:0] lo, hi;

  // The lower byte sits at idx, the upper at idx+1; one of them is even.
  assign idx_p1 = rd_i.idx + fat12ccs_pkg::ADDR_W'(1);

  always_ff @(posedge clk_i) begin
    if (wr_i.en && !wr_i.addr[0]) begin
      even_mem[wr_i.addr[RowW:1]] <= wr_i.data;
    end
    if (wr_i.en && wr_i.addr[0]) begin
      odd_mem[wr_i.addr[RowW:1]] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      even_q <= even_mem[idx_p1[RowW:1]];
      odd_q  <= odd_mem[rd_i.idx[RowW:1]];
      sel_q  <= rd_i.idx[0];
      codd_q <= rd_i.odd;
    end
  end

  always_comb begin
    lo = sel_q ? odd_q : even_q;
    hi = sel_q ? even_q : odd_q;
    if (codd_q) begin
      entry_o = {hi, lo[7:4]};
    end else begin
      entry_o = {hi[3:0] & fat12ccs_pkg::NIBBLE, lo};
    end
  end

endmodule

// ----- test/fat12_cluster_chain_seek_tb.sv -----
// Self-checking testbench for the FAT12 cluster chain seek block.
// Depends on fat12ccs_pkg and fat12_cluster_chain_seek; reads no files.
`timescale 1ns / 1ps

// The bench keeps its own copy of the packed table, the open file and the
// remembered sector, and predicts the status, cluster and data sector of every
// word that the block accepts. A short directed plan builds a small chain with
// a loop, an end-of-chain link, a reserved link, a free link and a link that
// runs past the table, and probes them at the field extremes. Random traffic
// follows in phases, one per total_sectors setting, each phase written only
// once the block has drained.
//
// The table holds nothing defined until it is loaded, so before each seek the
// bench runs the walk on its model without committing it. Whenever the walk
// would touch an entry whose two bytes have not both been loaded, a random
// link is laid there with two load words, and the walk is tried again. Chains
// therefore grow as they are followed, with random content: mostly links into
// a small pool of clusters, so that loops and long walks occur, and now and
// then end of chain, reserved, free or far links.
module fat12_cluster_chain_seek_tb;
  import fat12ccs_pkg::*;

  localparam int SECTOR_BYTES = 512;
  localparam int FAT_SECTORS  = 9;
  localparam int DATA_START   = 33;
  localparam int TABLE_BYTES  = SECTOR_BYTES * FAT_SECTORS;

  localparam logic [11:0] FREE_LINK = 12'h000;
  localparam int POOL_LAST    = 60;       // highest cluster of the link pool
  localparam int MAX_IDLE     = 7;        // longest gap or stall per word
  localparam int PHASE_ITEMS  = 150;      // live words per setting
  localparam int SETTLE_CYCLES = 4;       // pause before a register write
  localparam int DRAIN_CYCLES = 20;
  // A seek of 65535 hops is the longest stretch that a correct block may
  // spend without any handshake.
  localparam int QUIET_LIMIT  = 500_000;

  typedef struct packed {
    kind_e       kind;
    logic [12:0] addr;
    logic [7:0]  data;
    logic [11:0] first;
    logic [24:0] offs;
  } word_t;

  typedef struct packed {
    status_e     st;
    logic [11:0] clu;
    logic [15:0] sec;
  } position_t;

  typedef struct {
    word_t     w;
    bit        typed;   // expectation given below rather than predicted
    position_t pos;
  } plan_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;

  // Model of the block: table bytes, which of them have been loaded, the
  // open file, the walk position and the sector bound.
  logic [7:0]  fat_copy [TABLE_BYTES];
  bit          fat_loaded [TABLE_BYTES];
  logic [11:0] start_clu;
  logic [11:0] cur_clu;
  logic [15:0] sect_pos;
  logic [15:0] total_sec;

  position_t   due_positions [$];
  bit          failed = 1'b0;
  bit          in_burst;
  bit          out_burst = 1'b0;
  int          out_stall = 0;
  int          live_items;
  int          quiet = 0;

  // Directed plan. Bytes 3 to 11 hold: cluster 2 -> 3, 3 -> 2 (a loop),
  // 4 -> end of chain, 5 -> reserved, 6 -> free, 7 -> 3839, whose data
  // sector lies past the default bound and whose entry lies past the table.
  plan_row_t plan [26] = '{
    '{'{KIND_LOAD, 13'd3,    8'h03, 12'd0,    25'd0},    1'b1, '{STAT_OK, 12'd0, 16'd31}},
    '{'{KIND_LOAD, 13'd4,    8'h20, 12'd0,    25'd0},    1'b1, '{STAT_OK, 12'd0, 16'd31}},
    '{'{KIND_LOAD, 13'd5,    8'h00, 12'd0,    25'd0},    1'b1, '{STAT_OK, 12'd0, 16'd31}},
    '{'{KIND_LOAD, 13'd6,    8'hFF, 12'd0,    25'd0},    1'b1, '{STAT_OK, 12'd0, 16'd31}},
    '{'{KIND_LOAD, 13'd7,    8'h7F, 12'd0,    25'd0},    1'b1, '{STAT_OK, 12'd0, 16'd31}},
    '{'{KIND_LOAD, 13'd8,    8'hFF, 12'd0,    25'd0},    1'b0, '0},
    '{'{KIND_LOAD, 13'd9,    8'h00, 12'd0,    25'd0},    1'b0, '0},
    '{'{KIND_LOAD, 13'd10,   8'hF0, 12'd0,    25'd0},    1'b0, '0},
    '{'{KIND_LOAD, 13'd11,   8'hEF, 12'd0,    25'd0},    1'b0, '0},
    // An address past the table is dropped.
    '{'{KIND_LOAD, 13'd8191, 8'hAA, 12'd0,    25'd0},    1'b1, '{STAT_OK, 12'd0, 16'd31}},
    '{'{KIND_SEEK, 13'd0,    8'h00, 12'd0,    25'd0},    1'b1, '{STAT_OK, 12'd0, 16'd31}},
    '{'{KIND_OPEN, 13'd0,    8'h00, 12'd2,    25'd0},    1'b1, '{STAT_OK, 12'd2, 16'd33}},
    '{'{KIND_SEEK, 13'd0,    8'h00, 12'd0,    25'd1536}, 1'b0, '0},
    // Going back rewinds to the start cluster.
    '{'{KIND_SEEK, 13'd0,    8'h00, 12'd0,    25'd511},  1'b1, '{STAT_OK, 12'd2, 16'd33}},
    '{'{KIND_OPEN, 13'd0,    8'h00, 12'd4,    25'd0},    1'b1, '{STAT_OK, 12'd4, 16'd35}},
    '{'{KIND_SEEK, 13'd0,    8'h00, 12'd0,    25'd512},  1'b1, '{STAT_EOC, 12'd4, 16'd35}},
    '{'{KIND_OPEN, 13'd0,    8'h00, 12'd5,    25'd0},    1'b1, '{STAT_OK, 12'd5, 16'd36}},
    '{'{KIND_SEEK, 13'd0,    8'h00, 12'd0,    25'd1000}, 1'b1, '{STAT_EIO, 12'd5, 16'd36}},
    '{'{KIND_OPEN, 13'd0,    8'h00, 12'd6,    25'd0},    1'b1, '{STAT_OK, 12'd6, 16'd37}},
    '{'{KIND_SEEK, 13'd0,    8'h00, 12'd0,    25'd512},  1'b1, '{STAT_EIO, 12'd6, 16'd37}},
    '{'{KIND_OPEN, 13'd0,    8'h00, 12'd7,    25'd0},    1'b1, '{STAT_OK, 12'd7, 16'd38}},
    '{'{KIND_SEEK, 13'd0,    8'h00, 12'd0,    25'd1024}, 1'b0, '0},
    '{'{KIND_OPEN, 13'd0,    8'h00, 12'd4095, 25'd0},    1'b1, '{STAT_OK, 12'd4095, 16'd4126}},
    '{'{KIND_SEEK, 13'd0,    8'h00, 12'd0,    25'h1FFFFFF}, 1'b1,
      '{STAT_EIO, 12'd4095, 16'd4126}},
    '{'{KIND_OPEN, 13'd0,    8'h00, 12'd2,    25'd0},    1'b1, '{STAT_OK, 12'd2, 16'd33}},
    // The full 65535 hops round the loop of clusters 2 and 3.
    '{'{KIND_SEEK, 13'd0,    8'h00, 12'd0,    25'h1FFFFFF}, 1'b0, '0}
  };

  fat12_cluster_chain_seek #(
    .SECTOR_BYTES(SECTOR_BYTES),
    .FAT_SECTORS (FAT_SECTORS),
    .DATA_START  (DATA_START)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The 12-bit entry of a cluster, assembled from its two table bytes.
  function automatic logic [11:0] link_of(input logic [11:0] clu);
    int unsigned idx;
    idx = (3 * clu) / 2;
    if (clu[0]) return {fat_copy[idx + 1], fat_copy[idx][7:4]};
    return {fat_copy[idx + 1][3:0], fat_copy[idx]};
  endfunction

  // Follows the chain for a seek. Without commit the model is left as it
  // was, and need names the first cluster whose entry has not been loaded
  // (or -1 if there is none). Entries are demanded even where the sector
  // bound would stop the hop, so that the block never reads an empty entry.
  function automatic status_e chain_seek(input logic [24:0] offs, input bit commit,
                                         output int need);
    int unsigned target;
    int unsigned pos;
    int unsigned idx;
    logic [11:0] clu;
    logic [11:0] link;
    status_e     st;
    target = offs / SECTOR_BYTES;
    if (target > SECTOR_SAT) target = SECTOR_SAT;
    pos  = sect_pos;
    clu  = cur_clu;
    st   = STAT_OK;
    need = -1;
    if (target < pos) begin
      pos = 0;
      clu = start_clu;
    end
    while (target > pos && st == STAT_OK) begin
      idx = (3 * clu) / 2;
      if (idx + 1 < TABLE_BYTES && !(fat_loaded[idx] && fat_loaded[idx + 1])) begin
        need = clu;
        return STAT_OK;
      end
      if (clu + DATA_START - 2 > total_sec) begin
        st = STAT_EIO;
      end else if (idx + 1 >= TABLE_BYTES) begin
        st = STAT_EIO;
      end else begin
        link = link_of(clu);
        if (link >= LINK_END) st = STAT_EOC;
        else if (link >= LINK_RESERVED || link == FREE_LINK) st = STAT_EIO;
        else begin
          clu = link;
          pos++;
        end
      end
    end
    if (commit) begin
      cur_clu = clu;
      if (st == STAT_OK) sect_pos = target;
    end
    return st;
  endfunction

  // Applies one word to the model and returns the position that it reports.
  function automatic position_t predict_position(input word_t w);
    position_t res;
    int        need;
    res.st = STAT_OK;
    case (w.kind)
      KIND_LOAD: begin
        if (w.addr < TABLE_BYTES) begin
          fat_copy[w.addr]   = w.data;
          fat_loaded[w.addr] = 1'b1;
        end
      end
      KIND_OPEN: begin
        start_clu = w.first;
        cur_clu   = w.first;
        sect_pos  = '0;
      end
      KIND_SEEK: res.st = chain_seek(w.offs, 1'b1, need);
      default: ;
    endcase
    res.clu = cur_clu;
    res.sec = 16'(cur_clu + DATA_START - 2);
    return res;
  endfunction

  function automatic word_t random_word(input kind_e kind);
    word_t w;
    w.kind  = kind;
    w.addr  = 13'($urandom);
    w.data  = 8'($urandom);
    w.first = 12'($urandom);
    w.offs  = 25'($urandom);
    return w;
  endfunction

  // Presents one word after a random gap and waits for it to be taken. The
  // expected position is queued at the edge that accepts the word.
  task automatic send_word(input word_t w, input bit typed, input position_t typed_pos);
    int        gap;
    position_t due;
    due = predict_position(w);
    if (typed) due = typed_pos;
    gap = in_burst ? 0 : $urandom_range(0, MAX_IDLE);
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, w.offs, w.first, w.data, w.addr};
    s_axis_tuser  <= w.kind;
    do @(posedge clk_i); while (!s_axis_tready);
    due_positions.push_back(due);
    if (w.kind != KIND_LOAD || w.addr < TABLE_BYTES) live_items++;
  endtask

  // Lays a random link for a cluster with two load words, keeping the nibble
  // that belongs to the neighbouring entry where it has already been loaded.
  task automatic lay_link(input logic [11:0] clu);
    int unsigned idx;
    int unsigned pick;
    logic [11:0] link;
    word_t       w;
    idx  = (3 * clu) / 2;
    pick = $urandom_range(0, 99);
    if (pick < 70)      link = 12'($urandom_range(2, POOL_LAST));
    else if (pick < 78) link = 12'($urandom_range(2, LINK_RESERVED - 1));
    else if (pick < 85) link = 12'($urandom_range(LINK_END, LINK_MASK));
    else if (pick < 92) link = 12'($urandom_range(LINK_RESERVED, LINK_END - 1));
    else                link = FREE_LINK;
    w = random_word(KIND_LOAD);
    w.addr = 13'(idx);
    if (clu[0])
      w.data = {link[3:0], fat_loaded[idx] ? fat_copy[idx][3:0] : 4'($urandom)};
    else
      w.data = link[7:0];
    send_word(w, 1'b0, '0);
    w = random_word(KIND_LOAD);
    w.addr = 13'(idx + 1);
    if (clu[0])
      w.data = link[11:4];
    else
      w.data = {fat_loaded[idx + 1] ? fat_copy[idx + 1][7:4] : 4'($urandom), link[11:8]};
    send_word(w, 1'b0, '0);
  endtask

  // Mostly short seeks within a dozen sectors; now and then one across the
  // whole offset range, which may take tens of thousands of hops.
  task automatic seek_somewhere();
    logic [24:0] offs;
    int          need;
    word_t       w;
    if ($urandom_range(0, 149) == 0)
      offs = 25'($urandom);
    else
      offs = 25'($urandom_range(0, 12) * SECTOR_BYTES + $urandom_range(0, SECTOR_BYTES - 1));
    do begin
      void'(chain_seek(offs, 1'b0, need));
      if (need >= 0) lay_link(12'(need));
    end while (need >= 0);
    w = random_word(KIND_SEEK);
    w.offs = offs;
    send_word(w, 1'b0, '0);
  endtask

  // The bound may only change while the block is idle, so every result
  // must be in before the write.
  task automatic set_total_sectors(input logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    while (due_positions.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    total_sec = value;
  endtask

  // Result side: every word is checked against the oldest expectation, and
  // ready is held low for a random number of cycles after each one.
  always @(posedge clk_i) begin : result_check
    position_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_positions.size() == 0) begin
          $error("result word with no expectation: %h", m_axis_tdata);
          failed = 1'b1;
        end else begin
          want = due_positions.pop_front();
          if (m_axis_tdata[1:0] !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, m_axis_tdata[1:0]);
            failed = 1'b1;
          end
          if (m_axis_tdata[13:2] !== want.clu) begin
            $error("cluster: expected %0d, got %0d", want.clu, m_axis_tdata[13:2]);
            failed = 1'b1;
          end
          if (m_axis_tdata[29:14] !== want.sec) begin
            $error("sector: expected %0d, got %0d", want.sec, m_axis_tdata[29:14]);
            failed = 1'b1;
          end
        end
        out_stall = out_burst ? 0 : $urandom_range(0, MAX_IDLE);
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      end
      if (out_stall > 0) begin
        m_axis_tready <= 1'b0;
        out_stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Ends the run if no word moves on any channel for too long.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("fat12_cluster_chain_seek test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    word_t      w;
    int         phase_start;
    int unsigned pick;
    logic [15:0] caps [5];
    caps = '{16'hFFFF, 16'd0, 16'd100, TOTAL_RESET, 16'd40};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    in_burst      = 1'b0;
    live_items    = 0;
    start_clu     = '0;
    cur_clu       = '0;
    sect_pos      = '0;
    total_sec     = TOTAL_RESET;
    foreach (fat_loaded[i]) begin
      fat_loaded[i] = 1'b0;
      fat_copy[i]   = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) send_word(plan[i].w, plan[i].typed, plan[i].pos);

    // The first phase runs at the reset bound, the last at a random one.
    for (int p = 0; p < 7; p++) begin
      if (p > 0) set_total_sectors(p <= 5 ? caps[p - 1] : 16'($urandom));
      phase_start = live_items;
      while (live_items - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // An open followed by a run of seeks through the same file.
          w = random_word(KIND_OPEN);
          if ($urandom_range(0, 9) != 0) w.first = 12'($urandom_range(2, POOL_LAST));
          send_word(w, 1'b0, '0);
          repeat ($urandom_range(1, 5)) seek_somewhere();
        end else if (pick < 80) begin
          seek_somewhere();
        end else if (pick < 90) begin
          send_word(random_word(KIND_LOAD), 1'b0, '0);
        end else begin
          send_word(random_word(KIND_OPEN), 1'b0, '0);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (due_positions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (!failed) begin
      $display("fat12_cluster_chain_seek test passed");
    end else begin
      $display("fat12_cluster_chain_seek test failed");
    end
    $finish;
  end

endmodule
